### sv/mprc_pkg.sv
// Package for the mesh receive packet classifier.
// Holds the transaction payload types, action, type and register codes.
// No dependencies.
package mprc_pkg;

   typedef struct packed {
      logic [7:0] net_src;
      logic [7:0] net_dst;
      logic [2:0] pkt_type;
      logic       ack_flag;
      logic [7:0] hop_count;
      logic [1:0] sub_kind;
      logic [7:0] packet_id;
   } mprc_req_type;

   typedef struct packed {
      logic [3:0]  action;
      logic [2:0]  out_type;
      logic [7:0]  out_src;
      logic [7:0]  out_dst;
      logic [7:0]  out_hop;
      logic [1:0]  out_sub;
      logic        out_ack;
      logic [7:0]  out_id;
      logic [31:0] delivered_count;
      logic [31:0] drop_count;
      logic [31:0] hop_drop_count;
   } mprc_rsp_type;

   localparam logic [3:0] ACT_DELIVER   = 4'd0;
   localparam logic [3:0] ACT_PING_REP  = 4'd1;
   localparam logic [3:0] ACT_ROUTE_RSP = 4'd2;
   localparam logic [3:0] ACT_FORWARD   = 4'd3;
   localparam logic [3:0] ACT_FWD_RSP   = 4'd4;
   localparam logic [3:0] ACT_DUP_DROP  = 4'd5;
   localparam logic [3:0] ACT_HOP_DROP  = 4'd6;
   localparam logic [3:0] ACT_TYPE_DROP = 4'd7;
   localparam logic [3:0] ACT_NONE      = 4'd8;

   localparam logic [2:0] PKT_DATA     = 3'd0;
   localparam logic [2:0] PKT_DATA_ACK = 3'd1;
   localparam logic [2:0] PKT_PING     = 3'd2;
   localparam logic [2:0] PKT_ROUTE    = 3'd3;

   localparam logic [1:0] SUB_REQUEST  = 2'd0;
   localparam logic [1:0] SUB_RESPONSE = 2'd1;

   localparam int         CSR_ADDR_W     = 4;
   localparam logic [1:0] REG_LOCAL_ADDR = 2'd0;
   localparam logic [1:0] REG_BCAST_ADDR = 2'd1;
   localparam logic [1:0] REG_HOP_LIMIT  = 2'd2;

   localparam logic [7:0] LOCAL_ADDR_RST = 8'd0;
   localparam logic [7:0] BCAST_ADDR_RST = 8'd255;
   localparam logic [7:0] HOP_LIMIT_RST  = 8'd8;

endpackage

### sv/mprc_req_if.sv
// Channel interface for received packet headers.
// Depends on mprc_pkg for the payload type.
interface mprc_req_if import mprc_pkg::*; ();
   logic         valid;
   logic         ready;
   mprc_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/mprc_rsp_if.sv
// Channel interface for classification results.
// Depends on mprc_pkg for the payload type.
interface mprc_rsp_if import mprc_pkg::*; ();
   logic         valid;
   logic         ready;
   mprc_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/mesh_rx_packet_classifier_unit.sv
// Top level of the mesh receive packet classifier.
// Depends on mprc_pkg, mprc_req_if and mprc_rsp_if.
//
// Channel   Direction  Handshake            Contents
// req_ch    in         valid/ready          one received header per transaction
// rsp_ch    out        valid/ready          action, outgoing header, counters
// APB       in         psel/penable/pready  local address, broadcast address, hop limit
//
// One transaction per cycle is sustained while rsp_ch is not stalled. A result is offered after acceptance:
// the id memory is read as the header is accepted, and the decision is registered from both.
// The most recent id write is held and forwarded to the reader when it hits the same entry.
// Reset clears counters and the per-source valid bits and loads the configuration defaults.
// A stalled result holds the decision stage, which then stops new acceptance.
module mesh_rx_packet_classifier_unit import mprc_pkg::*; #(
   parameter int NODE_COUNT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   mprc_req_if.sink              req_ch,
   mprc_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int         IDX_W    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam logic [8:0] NODE_LIM = 9'(NODE_COUNT);

   logic [7:0] local_addr_ff;
   logic [7:0] bcast_addr_ff;
   logic [7:0] hop_limit_ff;

   logic              s1_valid_ff;
   mprc_req_type      s1_pkt_ff;
   logic [7:0]        rd_id_ff;
   logic [7:0]        id_mem [NODE_COUNT];
   logic [NODE_COUNT-1:0] seen_ff;
   logic              fwd_valid_ff;
   logic [IDX_W-1:0]  fwd_idx_ff;
   logic [7:0]        fwd_id_ff;

   logic [31:0] delivered_ff, delivered_in;
   logic [31:0] dropped_ff, dropped_in;
   logic [31:0] hop_dropped_ff, hop_dropped_in;

   logic         rsp_valid_ff;
   mprc_rsp_type rsp_data_ff, rsp_data_in;

   logic             req_fire;
   logic             s1_adv;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] s1_idx;
   logic             in_table;
   logic [7:0]       stored_id;
   logic             dup;
   logic             store_en;
   logic             csr_wr;

   assign csr_wr = psel & penable & pwrite & pready;
   assign pready = 1'b1;

   always_comb begin
      case (paddr[3:2])
         REG_LOCAL_ADDR: prdata = {24'd0, local_addr_ff};
         REG_BCAST_ADDR: prdata = {24'd0, bcast_addr_ff};
         REG_HOP_LIMIT:  prdata = {24'd0, hop_limit_ff};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= LOCAL_ADDR_RST;
         bcast_addr_ff <= BCAST_ADDR_RST;
         hop_limit_ff  <= HOP_LIMIT_RST;
      end else if (csr_wr) begin
         case (paddr[3:2])
            REG_LOCAL_ADDR: local_addr_ff <= pwdata[7:0];
            REG_BCAST_ADDR: bcast_addr_ff <= pwdata[7:0];
            REG_HOP_LIMIT:  hop_limit_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   assign s1_adv       = s1_valid_ff & (~rsp_valid_ff | rsp_ch.ready);
   assign req_ch.ready = ~s1_valid_ff | s1_adv;
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign rd_idx       = req_ch.data.net_src[IDX_W-1:0];
   assign s1_idx       = s1_pkt_ff.net_src[IDX_W-1:0];
   assign in_table     = {1'b0, s1_pkt_ff.net_src} < NODE_LIM;

   assign stored_id = (fwd_valid_ff && fwd_idx_ff == s1_idx) ? fwd_id_ff : rd_id_ff;
   assign dup = in_table & seen_ff[s1_idx] & (stored_id == s1_pkt_ff.packet_id);

   always_comb begin
      rsp_data_in    = '0;
      rsp_data_in.action = ACT_NONE;
      delivered_in   = delivered_ff;
      dropped_in     = dropped_ff;
      hop_dropped_in = hop_dropped_ff;
      store_en       = 1'b0;
      if (s1_pkt_ff.net_dst == local_addr_ff || s1_pkt_ff.net_dst == bcast_addr_ff) begin
         if (s1_pkt_ff.pkt_type == PKT_DATA ||
             (s1_pkt_ff.pkt_type == PKT_PING && s1_pkt_ff.ack_flag)) begin
            delivered_in         = delivered_ff + 32'd1;
            rsp_data_in.action   = ACT_DELIVER;
            rsp_data_in.out_type = s1_pkt_ff.pkt_type;
            rsp_data_in.out_src  = s1_pkt_ff.net_src;
            rsp_data_in.out_dst  = s1_pkt_ff.net_dst;
            rsp_data_in.out_hop  = s1_pkt_ff.hop_count;
            rsp_data_in.out_sub  = s1_pkt_ff.sub_kind;
            rsp_data_in.out_ack  = s1_pkt_ff.ack_flag;
            rsp_data_in.out_id   = s1_pkt_ff.packet_id;
         end else if (s1_pkt_ff.pkt_type == PKT_DATA_ACK) begin
            rsp_data_in.action = ACT_NONE;
         end else if (s1_pkt_ff.pkt_type == PKT_PING) begin
            rsp_data_in.action   = ACT_PING_REP;
            rsp_data_in.out_type = PKT_PING;
            rsp_data_in.out_src  = local_addr_ff;
            rsp_data_in.out_dst  = s1_pkt_ff.net_src;
            rsp_data_in.out_ack  = 1'b1;
         end else if (s1_pkt_ff.pkt_type == PKT_ROUTE) begin
            if (s1_pkt_ff.sub_kind == SUB_REQUEST) begin
               if (dup) begin
                  rsp_data_in.action = ACT_DUP_DROP;
               end else begin
                  store_en             = in_table;
                  rsp_data_in.action   = ACT_ROUTE_RSP;
                  rsp_data_in.out_type = PKT_ROUTE;
                  rsp_data_in.out_src  = local_addr_ff;
                  rsp_data_in.out_dst  = s1_pkt_ff.net_src;
                  rsp_data_in.out_hop  = s1_pkt_ff.hop_count;
                  rsp_data_in.out_sub  = SUB_RESPONSE;
                  rsp_data_in.out_ack  = s1_pkt_ff.ack_flag;
                  rsp_data_in.out_id   = s1_pkt_ff.packet_id;
               end
            end
         end else begin
            dropped_in         = dropped_ff + 32'd1;
            rsp_data_in.action = ACT_TYPE_DROP;
         end
      end else if (s1_pkt_ff.hop_count < hop_limit_ff) begin
         if (s1_pkt_ff.pkt_type != PKT_ROUTE || s1_pkt_ff.sub_kind == SUB_RESPONSE) begin
            rsp_data_in.action   = (s1_pkt_ff.pkt_type == PKT_ROUTE) ? ACT_FWD_RSP
                                                                     : ACT_FORWARD;
            rsp_data_in.out_type = s1_pkt_ff.pkt_type;
            rsp_data_in.out_src  = s1_pkt_ff.net_src;
            rsp_data_in.out_dst  = s1_pkt_ff.net_dst;
            rsp_data_in.out_hop  = (s1_pkt_ff.pkt_type == PKT_ROUTE) ? s1_pkt_ff.hop_count
                                                                     : s1_pkt_ff.hop_count + 8'd1;
            rsp_data_in.out_sub  = s1_pkt_ff.sub_kind;
            rsp_data_in.out_ack  = s1_pkt_ff.ack_flag;
            rsp_data_in.out_id   = s1_pkt_ff.packet_id;
         end
      end else begin
         hop_dropped_in     = hop_dropped_ff + 32'd1;
         dropped_in         = dropped_ff + 32'd1;
         rsp_data_in.action = ACT_HOP_DROP;
      end
      rsp_data_in.delivered_count = delivered_in;
      rsp_data_in.drop_count      = dropped_in;
      rsp_data_in.hop_drop_count  = hop_dropped_in;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_id_ff <= id_mem[rd_idx];
      end
      if (s1_adv && store_en) begin
         id_mem[s1_idx] <= s1_pkt_ff.packet_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         seen_ff        <= '0;
         delivered_ff   <= 32'd0;
         dropped_ff     <= 32'd0;
         hop_dropped_ff <= 32'd0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            delivered_ff   <= delivered_in;
            dropped_ff     <= dropped_in;
            hop_dropped_ff <= hop_dropped_in;
         end
         if (s1_adv && store_en) begin
            fwd_valid_ff    <= 1'b1;
            seen_ff[s1_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pkt_ff <= req_ch.data;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (s1_adv && store_en) begin
         fwd_idx_ff <= s1_idx;
         fwd_id_ff  <= s1_pkt_ff.packet_id;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule
